FILE: src/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the strict priority single server: storage
// sizes, entry layouts, result kinds and the controller state encoding.
// ----------------------------------------------------------------------------
package sps_pkg;

   localparam int NUM_TIERS  = 4;
   localparam int TIER_W     = 2;
   localparam int TIER_DEPTH = 16;
   localparam int LOG_DEPTH  = 32;

   localparam int TIER_PW  = $clog2(TIER_DEPTH);
   localparam int TIER_CW  = $clog2(TIER_DEPTH + 1);
   localparam int TIER_AW  = $clog2(NUM_TIERS * TIER_DEPTH);
   localparam int TIER_MEM = NUM_TIERS * TIER_DEPTH;
   localparam int LOG_PW   = $clog2(LOG_DEPTH);
   localparam int LOG_CW   = $clog2(LOG_DEPTH + 1);

   localparam logic [TIER_W-1:0] LAST_TIER = TIER_W'(NUM_TIERS - 1);
   localparam logic [15:0] BUSY_RESET = 16'd1000;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_ARRIVE = 2'd1;
   localparam logic [1:0] KIND_ANSWER = 2'd2;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] arrival;
      logic [7:0]  dur;
   } tier_entry_type;

   typedef struct packed {
      logic [7:0]        id;
      logic [TIER_W-1:0] tier;
      logic [15:0]       arrival;
   } log_entry_type;

   typedef struct packed {
      logic              push;
      logic              rd;
      logic              pop;
      logic [TIER_W-1:0] tier;
   } tier_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic push;
      logic rd;
      logic pop;
   } log_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOG_REQ,
      S_LOG_CHK,
      S_TIER_REQ,
      S_TIER_CHK,
      S_FINISH
   } state_type;

endpackage

FILE: src/sps_tier_store.sv
// ----------------------------------------------------------------------------
// sps_tier_store
// Four circular FIFOs sharing one synchronous memory, with per-tier head,
// tail and occupancy registers. Read data arrives in the cycle after rd.
// ----------------------------------------------------------------------------
module sps_tier_store (
   input  logic                    clock,
   input  logic                    reset,
   input  sps_pkg::tier_cmd_type   cmd,
   input  sps_pkg::tier_entry_type wr_data,
   output sps_pkg::queue_stat_type stat,
   output sps_pkg::tier_entry_type rd_data
);

   logic [sps_pkg::TIER_PW-1:0] head_ff  [sps_pkg::NUM_TIERS];
   logic [sps_pkg::TIER_PW-1:0] head_in  [sps_pkg::NUM_TIERS];
   logic [sps_pkg::TIER_PW-1:0] tail_ff  [sps_pkg::NUM_TIERS];
   logic [sps_pkg::TIER_PW-1:0] tail_in  [sps_pkg::NUM_TIERS];
   logic [sps_pkg::TIER_CW-1:0] count_ff [sps_pkg::NUM_TIERS];
   logic [sps_pkg::TIER_CW-1:0] count_in [sps_pkg::NUM_TIERS];

   sps_pkg::tier_entry_type mem [sps_pkg::TIER_MEM];
   sps_pkg::tier_entry_type rd_data_ff;

   logic [sps_pkg::TIER_PW-1:0] sel_head;
   logic [sps_pkg::TIER_PW-1:0] sel_tail;
   logic [sps_pkg::TIER_CW-1:0] sel_count;
   logic [sps_pkg::TIER_AW-1:0] base_addr;
   logic [sps_pkg::TIER_AW-1:0] wr_addr;
   logic [sps_pkg::TIER_AW-1:0] rd_addr;

   function automatic logic [sps_pkg::TIER_PW-1:0] ptr_next(
      input logic [sps_pkg::TIER_PW-1:0] ptr
   );
      if (ptr == sps_pkg::TIER_PW'(sps_pkg::TIER_DEPTH - 1)) begin
         return '0;
      end
      return ptr + sps_pkg::TIER_PW'(1);
   endfunction

   assign sel_head  = head_ff[cmd.tier];
   assign sel_tail  = tail_ff[cmd.tier];
   assign sel_count = count_ff[cmd.tier];

   assign stat.full  = (sel_count == sps_pkg::TIER_CW'(sps_pkg::TIER_DEPTH));
   assign stat.empty = (sel_count == '0);

   assign base_addr = sps_pkg::TIER_AW'(cmd.tier) * sps_pkg::TIER_AW'(sps_pkg::TIER_DEPTH);
   assign wr_addr   = base_addr + sps_pkg::TIER_AW'(sel_tail);
   assign rd_addr   = base_addr + sps_pkg::TIER_AW'(sel_head);
   assign rd_data   = rd_data_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.push) begin
         tail_in[cmd.tier] = ptr_next(sel_tail);
      end
      if (cmd.pop) begin
         head_in[cmd.tier] = ptr_next(sel_head);
      end
      count_in[cmd.tier] = sel_count + sps_pkg::TIER_CW'(cmd.push)
                           - sps_pkg::TIER_CW'(cmd.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sps_pkg::NUM_TIERS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

`ifndef SYNTH
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.empty)
      else $error("tier pop while empty");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && !cmd.pop) |=>
      count_ff[$past(cmd.tier)] == $past(sel_count) + sps_pkg::TIER_CW'(1))
      else $error("tier count did not follow push");
`endif

endmodule

FILE: src/sps_arrival_log.sv
// ----------------------------------------------------------------------------
// sps_arrival_log
// Circular arrival log in one synchronous memory. Entries are appended at
// the tail and inspected and retired from the head during a tick.
// ----------------------------------------------------------------------------
module sps_arrival_log (
   input  logic                    clock,
   input  logic                    reset,
   input  sps_pkg::log_cmd_type    cmd,
   input  sps_pkg::log_entry_type  wr_data,
   output sps_pkg::queue_stat_type stat,
   output sps_pkg::log_entry_type  rd_data
);

   logic [sps_pkg::LOG_PW-1:0] head_ff;
   logic [sps_pkg::LOG_PW-1:0] head_in;
   logic [sps_pkg::LOG_PW-1:0] tail_ff;
   logic [sps_pkg::LOG_PW-1:0] tail_in;
   logic [sps_pkg::LOG_CW-1:0] count_ff;
   logic [sps_pkg::LOG_CW-1:0] count_in;

   sps_pkg::log_entry_type mem [sps_pkg::LOG_DEPTH];
   sps_pkg::log_entry_type rd_data_ff;

   function automatic logic [sps_pkg::LOG_PW-1:0] ptr_next(
      input logic [sps_pkg::LOG_PW-1:0] ptr
   );
      if (ptr == sps_pkg::LOG_PW'(sps_pkg::LOG_DEPTH - 1)) begin
         return '0;
      end
      return ptr + sps_pkg::LOG_PW'(1);
   endfunction

   assign stat.full  = (count_ff == sps_pkg::LOG_CW'(sps_pkg::LOG_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rd_data    = rd_data_ff;

   always_comb begin
      head_in  = cmd.pop  ? ptr_next(head_ff) : head_ff;
      tail_in  = cmd.push ? ptr_next(tail_ff) : tail_ff;
      count_in = count_ff + sps_pkg::LOG_CW'(cmd.push) - sps_pkg::LOG_CW'(cmd.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[head_ff];
      end
   end

`ifndef SYNTH
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.full)
      else $error("log push while full");

   a_pop_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop && !cmd.push) |=> count_ff == $past(count_ff) - sps_pkg::LOG_CW'(1))
      else $error("log count did not follow pop");
`endif

endmodule

FILE: src/strict_priority_single_server.sv
// An enqueue item returns nothing.
// A tick reads each log entry and each tier head that it visits with a request
// state and a check state, skips tiers found empty, and skips the tier scan
// when the server is busy.
// Results leave through an output register; a result is held back one step
// so that the last flag is known, and output stall stretches the tick.
// Reset is synchronous: counts and pointers clear, tick is 0, busy-until 1000.
// ----------------------------------------------------------------------------
// strict_priority_single_server
// Four-tier strict priority, non-preemptive single server. A controller
// walks the arrival log and the tier heads held in two memories per tick.
// ----------------------------------------------------------------------------
module strict_priority_single_server (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_caller_id,
   input  logic [1:0]  req_tier,
   input  logic [15:0] req_arrival_time,
   input  logic [7:0]  req_duration,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_tick_number,
   output logic [7:0]  rsp_out_caller_id,
   output logic [1:0]  rsp_out_tier,
   output logic        rsp_last
);

   sps_pkg::state_type state_ff, state_in;
   logic [sps_pkg::TIER_W-1:0] scan_ff, scan_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] busy_until_ff, busy_until_in;
   logic        busy_ff, busy_in;

   // The result produced most recently, still waiting to learn if it is last.
   logic [1:0]                 pend_kind_ff, pend_kind_in;
   logic [7:0]                 pend_id_ff, pend_id_in;
   logic [sps_pkg::TIER_W-1:0] pend_tier_ff, pend_tier_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_tick_ff, rsp_tick_in;
   logic [7:0]  rsp_id_ff, rsp_id_in;
   logic [1:0]  rsp_tier_ff, rsp_tier_in;
   logic        rsp_last_ff, rsp_last_in;

   logic out_free;

   sps_pkg::tier_cmd_type   tier_cmd;
   sps_pkg::tier_entry_type tier_wr;
   sps_pkg::tier_entry_type tier_rd;
   sps_pkg::queue_stat_type tier_stat;
   sps_pkg::log_cmd_type    log_cmd;
   sps_pkg::log_entry_type  log_wr;
   sps_pkg::log_entry_type  log_rd;
   sps_pkg::queue_stat_type log_stat;

   sps_tier_store u_tier_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tier_cmd),
      .wr_data (tier_wr),
      .stat    (tier_stat),
      .rd_data (tier_rd)
   );

   sps_arrival_log u_arrival_log (
      .clock   (clock),
      .reset   (reset),
      .cmd     (log_cmd),
      .wr_data (log_wr),
      .stat    (log_stat),
      .rd_data (log_rd)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != sps_pkg::S_IDLE);

   assign tier_wr.id      = req_caller_id;
   assign tier_wr.arrival = req_arrival_time;
   assign tier_wr.dur     = req_duration;
   assign log_wr.id       = req_caller_id;
   assign log_wr.tier     = req_tier;
   assign log_wr.arrival  = req_arrival_time;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_tick_number   = rsp_tick_ff;
   assign rsp_out_caller_id = rsp_id_ff;
   assign rsp_out_tier      = rsp_tier_ff;
   assign rsp_last          = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      tick_in       = tick_ff;
      busy_until_in = busy_until_ff;
      busy_in       = busy_ff;
      pend_kind_in  = pend_kind_ff;
      pend_id_in    = pend_id_ff;
      pend_tier_in  = pend_tier_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_tick_in   = rsp_tick_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_tier_in   = rsp_tier_ff;
      rsp_last_in   = rsp_last_ff;
      tier_cmd      = '0;
      tier_cmd.tier = scan_ff;
      log_cmd       = '0;

      case (state_ff)
         sps_pkg::S_IDLE: begin
            tier_cmd.tier = req_tier;
            if (req_valid) begin
               if (req_mode == sps_pkg::MODE_TICK) begin
                  pend_kind_in = sps_pkg::KIND_START;
                  pend_id_in   = '0;
                  pend_tier_in = '0;
                  busy_in      = busy_ff && (tick_ff != busy_until_ff);
                  state_in     = sps_pkg::S_LOG_REQ;
               end else begin
                  tier_cmd.push = !tier_stat.full;
                  log_cmd.push  = !tier_stat.full && !log_stat.full;
               end
            end
         end
         sps_pkg::S_LOG_REQ: begin
            if (log_stat.empty) begin
               scan_in  = '0;
               state_in = sps_pkg::S_TIER_REQ;
            end else begin
               log_cmd.rd = 1'b1;
               state_in   = sps_pkg::S_LOG_CHK;
            end
         end
         sps_pkg::S_LOG_CHK: begin
            if (log_rd.arrival > tick_ff) begin
               scan_in  = '0;
               state_in = sps_pkg::S_TIER_REQ;
            end else if (log_rd.arrival == tick_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pend_kind_ff;
                  rsp_tick_in  = tick_ff;
                  rsp_id_in    = pend_id_ff;
                  rsp_tier_in  = pend_tier_ff;
                  rsp_last_in  = 1'b0;
                  pend_kind_in = sps_pkg::KIND_ARRIVE;
                  pend_id_in   = log_rd.id;
                  pend_tier_in = log_rd.tier;
                  log_cmd.pop  = 1'b1;
                  state_in     = sps_pkg::S_LOG_REQ;
               end
            end else begin
               // Stale entry: retire it without a result.
               log_cmd.pop = 1'b1;
               state_in    = sps_pkg::S_LOG_REQ;
            end
         end
         sps_pkg::S_TIER_REQ: begin
            if (busy_ff) begin
               state_in = sps_pkg::S_FINISH;
            end else if (tier_stat.empty) begin
               if (scan_ff == sps_pkg::LAST_TIER) begin
                  state_in = sps_pkg::S_FINISH;
               end else begin
                  scan_in = scan_ff + sps_pkg::TIER_W'(1);
               end
            end else begin
               tier_cmd.rd = 1'b1;
               state_in    = sps_pkg::S_TIER_CHK;
            end
         end
         sps_pkg::S_TIER_CHK: begin
            if (tier_rd.arrival <= tick_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = pend_kind_ff;
                  rsp_tick_in   = tick_ff;
                  rsp_id_in     = pend_id_ff;
                  rsp_tier_in   = pend_tier_ff;
                  rsp_last_in   = 1'b0;
                  pend_kind_in  = sps_pkg::KIND_ANSWER;
                  pend_id_in    = tier_rd.id;
                  pend_tier_in  = scan_ff;
                  busy_in       = 1'b1;
                  busy_until_in = tick_ff + {8'd0, tier_rd.dur};
                  tier_cmd.pop  = 1'b1;
                  state_in      = sps_pkg::S_FINISH;
               end
            end else if (scan_ff == sps_pkg::LAST_TIER) begin
               state_in = sps_pkg::S_FINISH;
            end else begin
               scan_in  = scan_ff + sps_pkg::TIER_W'(1);
               state_in = sps_pkg::S_TIER_REQ;
            end
         end
         sps_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_tick_in  = tick_ff;
               rsp_id_in    = pend_id_ff;
               rsp_tier_in  = pend_tier_ff;
               rsp_last_in  = 1'b1;
               tick_in      = tick_ff + 16'd1;
               state_in     = sps_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sps_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sps_pkg::S_IDLE;
         scan_ff       <= '0;
         tick_ff       <= '0;
         busy_until_ff <= sps_pkg::BUSY_RESET;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         tick_ff       <= tick_in;
         busy_until_ff <= busy_until_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      pend_tier_ff <= pend_tier_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_tick_ff  <= rsp_tick_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_tier_ff  <= rsp_tier_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strict priority single server. A scripted and
// randomized call sequence is driven with random gaps and output stalls; every
// result is compared against an in-bench model of the tier queues, the arrival
// log and the server, including a zero-duration call that holds the server.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int RANDOM_ITEMS = 340;
   localparam int SETTLE_WAIT  = 100;

   typedef struct packed {
      logic        mode;
      logic [7:0]  id;
      logic [1:0]  tier;
      logic [15:0] arrival;
      logic [7:0]  dur;
   } call_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] tick;
      logic [7:0]  id;
      logic [1:0]  tier;
      logic        last;
   } call_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = sps_pkg::MODE_ENQUEUE;
   logic [7:0]  req_caller_id = 8'd0;
   logic [1:0]  req_tier = 2'd0;
   logic [15:0] req_arrival_time = 16'd0;
   logic [7:0]  req_duration = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_tick_number;
   logic [7:0]  rsp_out_caller_id;
   logic [1:0]  rsp_out_tier;
   logic        rsp_last;

   // Model of the switchboard.
   sps_pkg::tier_entry_type tier_q [sps_pkg::NUM_TIERS][sps_pkg::TIER_DEPTH];
   int                      tier_fill [sps_pkg::NUM_TIERS];
   sps_pkg::log_entry_type  arrivals [$];
   logic [15:0]             now_tick = 16'd0;
   logic [15:0]             free_at = sps_pkg::BUSY_RESET;
   logic                    serving = 1'b0;

   call_req_type   call_script [$];
   call_event_type calls_due [$];
   call_req_type   on_bus;
   logic [15:0] script_tick = 16'd0;
   int          queued_count = 0;
   int          accepted_count = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   logic        quiet_run = 1'b0;
   int          req_gap = 0;
   int          req_idle_pct = 0;
   int          stall_left = 0;
   int          stall_pct = 0;
   int          drive_cycles = 0;

   strict_priority_single_server u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_caller_id     (req_caller_id),
      .req_tier          (req_tier),
      .req_arrival_time  (req_arrival_time),
      .req_duration      (req_duration),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_tick_number   (rsp_tick_number),
      .rsp_out_caller_id (rsp_out_caller_id),
      .rsp_out_tier      (rsp_out_tier),
      .rsp_last          (rsp_last)
   );

   always #2 clock = ~clock;

   function automatic void admit_caller(input call_req_type c);
      sps_pkg::tier_entry_type te;
      sps_pkg::log_entry_type  le;
      // A full tier drops the item completely, log included.
      if (tier_fill[c.tier] >= sps_pkg::TIER_DEPTH) return;
      te.id      = c.id;
      te.arrival = c.arrival;
      te.dur     = c.dur;
      tier_q[c.tier][tier_fill[c.tier]] = te;
      tier_fill[c.tier]++;
      if (arrivals.size() < sps_pkg::LOG_DEPTH) begin
         le.id      = c.id;
         le.tier    = c.tier;
         le.arrival = c.arrival;
         arrivals.push_back(le);
      end
   endfunction

   function automatic void serve_tick();
      call_event_type ev;
      sps_pkg::tier_entry_type head;
      logic answered;
      int t;
      int k;
      ev = '{sps_pkg::KIND_START, now_tick, 8'd0, 2'd0, 1'b0};
      calls_due.push_back(ev);
      if (now_tick == free_at) serving = 1'b0;
      // The walk stops at the first entry still in the future.
      while (arrivals.size() > 0 && arrivals[0].arrival <= now_tick) begin
         if (arrivals[0].arrival == now_tick) begin
            ev = '{sps_pkg::KIND_ARRIVE, now_tick, arrivals[0].id, arrivals[0].tier,
                   1'b0};
            calls_due.push_back(ev);
         end
         void'(arrivals.pop_front());
      end
      if (!serving) begin
         answered = 1'b0;
         for (t = 0; t < sps_pkg::NUM_TIERS && !answered; t++) begin
            if (tier_fill[t] > 0 && tier_q[t][0].arrival <= now_tick) begin
               head = tier_q[t][0];
               ev = '{sps_pkg::KIND_ANSWER, now_tick, head.id, sps_pkg::TIER_W'(t), 1'b0};
               calls_due.push_back(ev);
               serving  = 1'b1;
               free_at  = now_tick + {8'd0, head.dur};
               for (k = 0; k < tier_fill[t] - 1; k++) tier_q[t][k] = tier_q[t][k + 1];
               tier_fill[t]--;
               answered = 1'b1;
            end
         end
      end
      ev = calls_due.pop_back();
      ev.last = 1'b1;
      calls_due.push_back(ev);
      now_tick = now_tick + 16'd1;
   endfunction

   task automatic queue_call(input logic [7:0] id, input logic [1:0] tier,
                             input logic [15:0] arrival, input logic [7:0] dur);
      call_script.push_back('{sps_pkg::MODE_ENQUEUE, id, tier, arrival, dur});
      queued_count++;
   endtask

   // The ignored fields of a tick carry random junk.
   task automatic queue_tick();
      call_script.push_back('{sps_pkg::MODE_TICK, 8'($urandom), 2'($urandom),
                              16'($urandom), 8'($urandom)});
      queued_count++;
      script_tick = script_tick + 16'd1;
   endtask

   // Most callers arrive at or just after the next tick; a few lie in the past.
   task automatic queue_random_caller(input logic [1:0] tier);
      logic [15:0] arrival;
      logic [7:0]  dur;
      int          shape;
      shape = $urandom_range(9);
      if (shape == 0) arrival = 16'($urandom_range(0, int'(script_tick)));
      else if (shape < 4) arrival = script_tick;
      else arrival = script_tick + 16'($urandom_range(1, 8));
      if ($urandom_range(9) == 0) dur = 8'($urandom_range(7, 40));
      else dur = 8'($urandom_range(1, 6));
      queue_call(8'($urandom), tier, arrival, dur);
   endtask

   task automatic wait_settled();
      while (accepted_count != queued_count || calls_due.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drive_cycles++;
         if (drive_cycles % 97 == 0) req_idle_pct = $urandom_range(2) * 12;
         if (req_valid && !req_stall) begin
            if (on_bus.mode == sps_pkg::MODE_TICK) serve_tick();
            else admit_caller(on_bus);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (!quiet_run && $urandom_range(99) < req_idle_pct) begin
               req_gap = $urandom_range(1, 11) - 1;
               req_valid <= 1'b0;
            end else if (call_script.size() > 0) begin
               on_bus = call_script.pop_front();
               req_valid        <= 1'b1;
               req_mode         <= on_bus.mode;
               req_caller_id    <= on_bus.id;
               req_tier         <= on_bus.tier;
               req_arrival_time <= on_bus.arrival;
               req_duration     <= on_bus.dur;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      call_event_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (calls_due.size() == 0) begin
               $display("%0t: result with none expected, expected nothing, got kind %0d tick %0d",
                        $time, rsp_kind, rsp_tick_number);
               mismatches++;
            end else begin
               want = calls_due.pop_front();
               compare_field("kind", 16'(want.kind), 16'(rsp_kind));
               compare_field("tick_number", want.tick, rsp_tick_number);
               compare_field("caller_id", 16'(want.id), 16'(rsp_out_caller_id));
               compare_field("tier", 16'(want.tier), 16'(rsp_out_tier));
               compare_field("last", 16'(want.last), 16'(rsp_last));
            end
         end
         if (drive_cycles % 89 == 0) stall_pct = $urandom_range(2) * 12;
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_run && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [15:0] base;
      int rand_count;
      int r;
      int n;
      int k;
      int round;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // A few empty ticks so that callers can lie in the past.
      repeat (8) queue_tick();

      // Priority among arrived heads, a head not yet arrived, an out-of-order
      // log with stale entries waiting behind a future one, and extreme ids.
      base = script_tick;
      queue_call(8'hFF, 2'd3, base, 8'd1);
      queue_call(8'h00, 2'd2, base, 8'd2);
      queue_call(8'h11, 2'd0, base + 16'd1, 8'd1);
      queue_call(8'h22, 2'd1, base - 16'd5, 8'd3);
      queue_call(8'h5A, 2'd3, 16'd0, 8'd4);
      repeat (6) queue_tick();

      // Bursts into one tier overflow its queue and the arrival log.
      rand_count = 0;
      while (rand_count < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 45) begin
            queue_tick();
            rand_count++;
         end else if (r < 85) begin
            queue_random_caller(2'($urandom));
            rand_count++;
         end else if (r < 94) begin
            n = $urandom_range(5, 20);
            k = $urandom_range(3);
            repeat (n) queue_random_caller(2'(k));
            rand_count += n;
         end else begin
            n = $urandom_range(3, 10);
            repeat (n) queue_tick();
            rand_count += n;
         end
      end
      wait_settled();
      quiet_run <= 1'b1;

      // Let the tiers drain for a while.
      for (round = 0; round < 12 && (serving || tier_fill[0] + tier_fill[1] +
           tier_fill[2] + tier_fill[3] != 0); round++) begin
         repeat (4) queue_tick();
         wait_settled();
      end

      // A zero duration keeps the server busy until the tick count wraps back;
      // a caller at the last tick value blocks the log behind it.
      queue_call(8'hC3, 2'd1, script_tick, 8'd0);
      queue_call(8'h96, 2'd3, script_tick, 8'd255);
      queue_call(8'h3C, 2'd0, 16'hFFFF, 8'd255);
      repeat (12) queue_tick();
      wait_settled();

      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: strict_priority_single_server.f
src/sps_pkg.sv
src/sps_tier_store.sv
src/sps_arrival_log.sv
src/strict_priority_single_server.sv
bench/tb_top.sv
